// ===== rtl/odo_pkg.sv =====
package odo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_RUN = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
  localparam logic [31:0] RATE_K = 32'd2935890503;

  // atan(2^-i) in binary angle units
  localparam logic [31:0] ATAN_TBL [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
    32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
    32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81,
    32'd41, 32'd20, 32'd10, 32'd5,
    32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef enum logic [4:0] {
    ST_IDLE, ST_MD, ST_MR, ST_ROT, ST_FIX,
    ST_XH, ST_XL, ST_XR, ST_XA,
    ST_YH, ST_YL, ST_YR, ST_YA,
    ST_RL, ST_RH, ST_RA, ST_PUB
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_DIST, MUL_ROT, MUL_HI, MUL_LO, MUL_KLO, MUL_KHI
  } mul_op_t;

  typedef struct packed {
    logic    take;
    mul_op_t mul_op;
    logic    ld_ud;
    logic    ld_m;
    logic    ld_ph;
    logic    rot_step;
    logic    fix;
    logic    use_s;
    logic    ld_q;
    logic    acc;
    logic    yaw_upd;
    logic    ld_out;
  } odo_cmd_t;

  typedef struct packed {
    logic cordic_last;
  } odo_stat_t;

endpackage

// ===== rtl/odo_if.sv =====
interface odo_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] linear_speed;
  logic signed [15:0] turn_rate;
  logic        [31:0] time_us;

  modport source(output valid, linear_speed, turn_rate, time_us, input ready);
  modport sink(input valid, linear_speed, turn_rate, time_us, output ready);
endinterface

interface odo_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] x_position;
  logic signed [47:0] y_position;
  logic        [31:0] heading;

  modport source(output valid, x_position, y_position, heading, input ready);
  modport sink(input valid, x_position, y_position, heading, output ready);
endinterface

// ===== rtl/odo_datapath.sv =====
module odo_datapath
  import odo_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  odo_cmd_t           cmd,
  output odo_stat_t          stat,
  input  logic signed [15:0] in_linear_speed,
  input  logic signed [15:0] in_turn_rate,
  input  logic        [31:0] in_time_us,
  output logic signed [47:0] out_x_position,
  output logic signed [47:0] out_y_position,
  output logic        [31:0] out_heading
);

  localparam logic signed [49:0] SAT_HI = 50'sd140737488355327;
  localparam logic signed [49:0] SAT_LO = -50'sd140737488355328;

  logic               started_r;
  logic        [31:0] last_time_r;
  logic signed [47:0] pos_x_r, pos_y_r;
  logic        [31:0] yaw_r;

  logic        [15:0] v_mag_r, w_mag_r;
  logic               v_neg_r, w_neg_r;
  logic        [31:0] dt_r;
  logic        [47:0] ud_r, m_r;
  logic        [63:0] prod_r, ph_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic        [4:0]  iter_r;
  logic               flip_r;
  logic signed [31:0] c_r, s_r;
  logic        [47:0] q_r;
  logic               q_neg_r;
  logic signed [47:0] out_x_r, out_y_r;
  logic        [31:0] out_hd_r;

  logic        [31:0] dt_nxt;
  logic        [31:0] ang_fold;
  logic               flip_nxt;
  logic        [31:0] mul_a, mul_b;
  logic signed [31:0] comp;
  logic        [30:0] uc;
  logic        [78:0] rnd_sum;
  logic signed [49:0] delta, acc_sum;
  logic signed [47:0] acc_sat;
  logic signed [33:0] dx, dy, atan_ext;
  logic signed [33:0] xf, yf;
  logic signed [31:0] c_nxt, s_nxt;
  logic        [31:0] yaw_step;

  assign dt_nxt   = started_r ? (in_time_us - last_time_r) : 32'd0;
  assign flip_nxt = yaw_r[31] ^ yaw_r[30];
  assign ang_fold = flip_nxt ? (yaw_r + 32'h8000_0000) : yaw_r;

  // shared 32x32 unsigned multiplier
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (cmd.mul_op)
      MUL_DIST: begin
        mul_a = {16'd0, v_mag_r};
        mul_b = dt_r;
      end
      MUL_ROT: begin
        mul_a = {16'd0, w_mag_r};
        mul_b = dt_r;
      end
      MUL_HI: begin
        mul_a = {8'd0, ud_r[47:24]};
        mul_b = {1'b0, uc};
      end
      MUL_LO: begin
        mul_a = {8'd0, ud_r[23:0]};
        mul_b = {1'b0, uc};
      end
      MUL_KLO: begin
        mul_a = m_r[31:0];
        mul_b = RATE_K;
      end
      MUL_KHI: begin
        mul_a = {16'd0, m_r[47:32]};
        mul_b = RATE_K;
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  assign comp = cmd.use_s ? s_r : c_r;
  assign uc   = comp[31] ? 31'(-comp) : comp[30:0];

  assign rnd_sum = {ph_r[54:0], 24'd0} + {15'd0, prod_r} + 79'(1 << 29);

  assign delta   = q_neg_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});
  assign acc_sum = (cmd.use_s ? {{2{pos_y_r[47]}}, pos_y_r} : {{2{pos_x_r[47]}}, pos_x_r})
                   + delta;

  always_comb begin
    if (acc_sum > SAT_HI) acc_sat = SAT_HI[47:0];
    else if (acc_sum < SAT_LO) acc_sat = SAT_LO[47:0];
    else acc_sat = acc_sum[47:0];
  end

  assign dx       = cy_r >>> iter_r;
  assign dy       = cx_r >>> iter_r;
  assign atan_ext = $signed({2'b00, ATAN_TBL[iter_r]});

  assign xf = flip_r ? -cx_r : cx_r;
  assign yf = flip_r ? -cy_r : cy_r;

  always_comb begin
    if (xf > ONE_Q30) c_nxt = ONE_Q30[31:0];
    else if (xf < -ONE_Q30) c_nxt = 32'(-ONE_Q30);
    else c_nxt = xf[31:0];
    if (yf > ONE_Q30) s_nxt = ONE_Q30[31:0];
    else if (yf < -ONE_Q30) s_nxt = 32'(-ONE_Q30);
    else s_nxt = yf[31:0];
  end

  // ph_r holds the low partial product, prod_r the high one
  assign yaw_step = prod_r[31:0] + ph_r[63:32] + {31'd0, ph_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      last_time_r <= 32'd0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      yaw_r       <= 32'd0;
    end else begin
      if (cmd.take) begin
        started_r   <= 1'b1;
        last_time_r <= in_time_us;
      end
      if (cmd.acc) begin
        if (cmd.use_s) pos_y_r <= acc_sat;
        else pos_x_r <= acc_sat;
      end
      if (cmd.yaw_upd) yaw_r <= w_neg_r ? (yaw_r - yaw_step) : (yaw_r + yaw_step);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      v_neg_r <= in_linear_speed[15];
      w_neg_r <= in_turn_rate[15];
      v_mag_r <= in_linear_speed[15] ? 16'(-in_linear_speed) : in_linear_speed;
      w_mag_r <= in_turn_rate[15] ? 16'(-in_turn_rate) : in_turn_rate;
      dt_r    <= dt_nxt;
      cx_r    <= GAIN_Q30;
      cy_r    <= '0;
      cz_r    <= {{2{ang_fold[31]}}, ang_fold};
      flip_r  <= flip_nxt;
      iter_r  <= 5'd0;
    end
    if (cmd.mul_op != MUL_NONE) prod_r <= 64'(mul_a) * 64'(mul_b);
    if (cmd.ld_ud) ud_r <= prod_r[47:0];
    if (cmd.ld_m) m_r <= prod_r[47:0];
    if (cmd.ld_ph) ph_r <= prod_r;
    if (cmd.rot_step) begin
      if (!cz_r[33]) begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - atan_ext;
      end else begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + atan_ext;
      end
      iter_r <= iter_r + 5'd1;
    end
    if (cmd.fix) begin
      c_r <= c_nxt;
      s_r <= s_nxt;
    end
    if (cmd.ld_q) begin
      q_r     <= rnd_sum[77:30];
      q_neg_r <= comp[31] ^ v_neg_r;
    end
    if (cmd.ld_out) begin
      out_x_r  <= pos_x_r;
      out_y_r  <= pos_y_r;
      out_hd_r <= yaw_r;
    end
  end

  assign stat.cordic_last = (iter_r == 5'(CORDIC_RUN - 1));

  assign out_x_position = out_x_r;
  assign out_y_position = out_y_r;
  assign out_heading    = out_hd_r;

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.fix) |-> (c_r <= $signed(ONE_Q30[31:0])) && (c_r >= 32'(-ONE_Q30))
      && (s_r <= $signed(ONE_Q30[31:0])) && (s_r >= 32'(-ONE_Q30)))
    else $error("cordic output outside unit range");

endmodule

// ===== rtl/odo_ctrl.sv =====
module odo_ctrl
  import odo_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  odo_stat_t stat,
  output odo_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   pub_ok;

  assign pub_ok = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MD;
      ST_MD:   state_nxt = ST_MR;
      ST_MR:   state_nxt = ST_ROT;
      ST_ROT:  if (stat.cordic_last) state_nxt = ST_FIX;
      ST_FIX:  state_nxt = ST_XH;
      ST_XH:   state_nxt = ST_XL;
      ST_XL:   state_nxt = ST_XR;
      ST_XR:   state_nxt = ST_XA;
      ST_XA:   state_nxt = ST_YH;
      ST_YH:   state_nxt = ST_YL;
      ST_YL:   state_nxt = ST_YR;
      ST_YR:   state_nxt = ST_YA;
      ST_YA:   state_nxt = ST_RL;
      ST_RL:   state_nxt = ST_RH;
      ST_RH:   state_nxt = ST_RA;
      ST_RA:   state_nxt = ST_PUB;
      ST_PUB:  if (pub_ok) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.mul_op = MUL_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_MD:  cmd.mul_op = MUL_DIST;
      ST_MR: begin
        cmd.mul_op = MUL_ROT;
        cmd.ld_ud  = 1'b1;
      end
      ST_ROT: cmd.rot_step = 1'b1;
      ST_FIX: begin
        cmd.fix  = 1'b1;
        cmd.ld_m = 1'b1;
      end
      ST_XH:  cmd.mul_op = MUL_HI;
      ST_XL: begin
        cmd.mul_op = MUL_LO;
        cmd.ld_ph  = 1'b1;
      end
      ST_XR:  cmd.ld_q = 1'b1;
      ST_XA:  cmd.acc = 1'b1;
      ST_YH: begin
        cmd.mul_op = MUL_HI;
        cmd.use_s  = 1'b1;
      end
      ST_YL: begin
        cmd.mul_op = MUL_LO;
        cmd.ld_ph  = 1'b1;
        cmd.use_s  = 1'b1;
      end
      ST_YR: begin
        cmd.ld_q  = 1'b1;
        cmd.use_s = 1'b1;
      end
      ST_YA: begin
        cmd.acc   = 1'b1;
        cmd.use_s = 1'b1;
      end
      ST_RL:  cmd.mul_op = MUL_KLO;
      ST_RH: begin
        cmd.mul_op = MUL_KHI;
        cmd.ld_ph  = 1'b1;
      end
      ST_RA:  cmd.yaw_upd = 1'b1;
      ST_PUB: cmd.ld_out = pub_ok;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.ld_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && state_r == ST_MD)
    else $error("second transaction taken while busy");

  a_pub_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PUB && out_valid_r && !out_ready |=> state_r == ST_PUB && out_valid_r)
    else $error("result overwritten while receiver stalls");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_ready) && !$past(cmd.ld_out))
    else $error("result dropped without transaction");

endmodule

// ===== rtl/unicycle_odometry_integrator_top.sv =====
// dead-reckoning pose integrator, euler step with an iterative cordic
// in_ch carries linear_speed (mm/s), turn_rate (mrad/s) and time_us (us);
// out_ch returns x_position, y_position (nm, saturating) and heading
// (2^32 units per turn), one result transaction per input transaction.
// both channels use valid/ready; a transaction happens when both are high.
// one item is in work at a time: in_ch.ready is high only while idle.
// from its input transaction to the point where it may leave the block, an
// item runs through the distance/rotation products, one cordic rotation per
// cycle on the single shared rotator, the x/y/heading updates on the one
// shared 32x32 multiplier, and the load of the output register.
// the result waits in an output register, so the next input is taken while
// the receiver stalls; a stalled result only blocks the item after it from
// being published. the first item after reset sees zero elapsed time.
// reset (rst_n low, synchronous) clears pose, heading and timestamp state
// and drops any result not yet taken.
module unicycle_odometry_integrator_top
  import odo_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  odo_in_if.sink     in_ch,
  odo_out_if.source  out_ch
);

  odo_cmd_t  cmd;
  odo_stat_t stat;

  odo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  odo_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_linear_speed (in_ch.linear_speed),
    .in_turn_rate    (in_ch.turn_rate),
    .in_time_us      (in_ch.time_us),
    .out_x_position  (out_ch.x_position),
    .out_y_position  (out_ch.y_position),
    .out_heading     (out_ch.heading)
  );

endmodule

// ===== dv/pose_checker.sv =====
module pose_checker
  import odo_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  odo_in_if         in_mon,
  odo_out_if        out_mon,
  output int        mismatches,
  output int        poses_due
);

  localparam longint POS_HI = 64'sd140737488355327;
  localparam longint POS_LO = -POS_HI - 1;

  typedef struct packed {
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic        [31:0] heading;
  } pose_t;

  // predicted pose state
  logic [31:0] prev_stamp;
  logic        seen_first;
  longint      pose_x;
  longint      pose_y;
  logic [31:0] yaw;

  pose_t pending_poses[$];
  pose_t want;
  int    fail_cnt;

  // round(d * c / 2^30), ties away from zero
  function automatic longint mul_q30_round(input longint d, input longint c);
    logic [63:0]  ud;
    logic [63:0]  uc;
    logic [127:0] prod;
    logic [127:0] q;
    ud = (d < 0) ? -d : d;
    uc = (c < 0) ? -c : c;
    prod = {64'd0, ud} * {64'd0, uc};
    q = (prod + (128'd1 << 29)) >> 30;
    return ((d < 0) != (c < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint clip_pos(input longint r);
    if (r > POS_HI) return POS_HI;
    if (r < POS_LO) return POS_LO;
    return r;
  endfunction

  function automatic pose_t integrate_pose(input logic signed [15:0] spd,
                                           input logic signed [15:0] rate,
                                           input logic        [31:0] stamp);
    logic [31:0] dt;
    logic [31:0] ang;
    logic        flip;
    longint      ticks, travel, turn;
    longint      cx, cy, z, dx, dy, arc, one;
    logic [63:0] mag, lo_prod, hi_prod, k, yaw_step;
    pose_t       res;
    if (!seen_first) begin
      seen_first = 1'b1;
      prev_stamp = stamp;
    end
    dt = stamp - prev_stamp;
    prev_stamp = stamp;
    ticks = longint'(dt);
    travel = longint'(spd) * ticks;
    turn = longint'(rate) * ticks;

    // headings in the left half plane are rotated by half a turn first
    flip = yaw[31] ^ yaw[30];
    ang = flip ? yaw + 32'h8000_0000 : yaw;
    z = longint'($signed(ang));
    cx = longint'(GAIN_Q30);
    cy = 0;
    for (int i = 0; i < CORDIC_RUN; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      arc = longint'(ATAN_TBL[i]);
      if (z >= 0) begin
        cx -= dx;
        cy += dy;
        z -= arc;
      end else begin
        cx += dx;
        cy -= dy;
        z += arc;
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    one = longint'(ONE_Q30);
    if (cx > one) cx = one;
    if (cx < -one) cx = -one;
    if (cy > one) cy = one;
    if (cy < -one) cy = -one;

    pose_x = clip_pos(pose_x + mul_q30_round(travel, cx));
    pose_y = clip_pos(pose_y + mul_q30_round(travel, cy));

    // heading step in binary angle units, rounded half up in magnitude
    mag = (turn < 0) ? -turn : turn;
    k = 64'(RATE_K);
    lo_prod = mag[31:0] * k;
    hi_prod = mag[63:32] * k;
    yaw_step = hi_prod + (lo_prod >> 32) + lo_prod[31];
    yaw = (turn < 0) ? yaw - yaw_step[31:0] : yaw + yaw_step[31:0];

    res.x = pose_x[47:0];
    res.y = pose_y[47:0];
    res.heading = yaw;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      prev_stamp = '0;
      seen_first = 1'b0;
      pose_x = 0;
      pose_y = 0;
      yaw = '0;
      fail_cnt = 0;
      pending_poses.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (pending_poses.size() == 0) begin
          $error("result transaction with no pose expected");
          fail_cnt++;
        end else begin
          want = pending_poses.pop_front();
          if (out_mon.x_position !== want.x) begin
            $error("x_position: expected %0d, got %0d", want.x, out_mon.x_position);
            fail_cnt++;
          end
          if (out_mon.y_position !== want.y) begin
            $error("y_position: expected %0d, got %0d", want.y, out_mon.y_position);
            fail_cnt++;
          end
          if (out_mon.heading !== want.heading) begin
            $error("heading: expected %0d, got %0d", want.heading, out_mon.heading);
            fail_cnt++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        pending_poses.push_back(integrate_pose(in_mon.linear_speed, in_mon.turn_rate,
                                               in_mon.time_us));
    end
    mismatches <= fail_cnt;
    poses_due <= pending_poses.size();
  end

endmodule

// ===== dv/tb_unicycle_odometry_integrator_top.sv =====
module tb_unicycle_odometry_integrator_top;

  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF = 400;
  localparam int DRAIN_CYCLES = 60;

  localparam int RX_OPEN = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_SPARSE = 2;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   poses_due;

  logic [31:0] stamp;
  int          burst_left;

  odo_in_if  in_ch ();
  odo_out_if out_ch ();

  unicycle_odometry_integrator_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pose_checker u_pose_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (mismatches),
    .poses_due  (poses_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("unicycle_odometry_integrator_top test failed");
    $finish;
  end

  // receiver: its own stall pattern, with two long hold-offs to back up the block
  initial begin
    int cyc;
    int mode;
    int left;
    out_ch.ready = 1'b0;
    cyc = 0;
    mode = RX_OPEN;
    left = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 3000 || cyc == 20000) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(RX_OPEN, RX_SPARSE);
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        RX_OPEN: begin
          out_ch.ready = 1'b1;
        end
        RX_RANDOM: begin
          out_ch.ready = 1'($urandom_range(0, 1));
        end
        default: begin
          out_ch.ready = ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // one velocity report, timestamped delta us after the previous one
  task automatic offer_reading(input logic signed [15:0] spd,
                               input logic signed [15:0] rate,
                               input logic        [31:0] delta);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      gap = $urandom_range(1, 50);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
    end
    burst_left--;
    stamp = stamp + delta;
    in_ch.valid = 1'b1;
    in_ch.linear_speed = spd;
    in_ch.turn_rate = rate;
    in_ch.time_us = stamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin
    logic signed [15:0] spd;
    logic signed [15:0] rate;
    logic        [31:0] delta;
    int                 pick;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.linear_speed = '0;
    in_ch.turn_rate = '0;
    in_ch.time_us = '0;
    stamp = 32'hFFFF_FFF0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // first report: no motion, only the timestamp is taken
    offer_reading(16'sh7FFF, 16'sh7FFF, 32'd0);
    // counter wraps through zero
    offer_reading(16'sd1000, -16'sd1000, 32'h20);
    offer_reading(-16'sh8000, -16'sh8000, 32'd50000);
    offer_reading(16'sd0, 16'sd0, 32'd20000);
    // timestamp steps back: read as a long interval, drives x/y into saturation
    offer_reading(16'sh7FFF, 16'sd0, 32'hFFFF_FFFF);
    offer_reading(16'sh7FFF, 16'sd0, 32'hFFFF_FFFF);
    offer_reading(16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF);
    offer_reading(-16'sh8000, 16'sd0, 32'hFFFF_FFFF);
    offer_reading(-16'sh8000, -16'sh8000, 32'hFFFF_FFFF);
    offer_reading(-16'sh8000, 16'sd0, 32'hFFFF_FFFF);
    offer_reading(-16'sh8000, 16'sd0, 32'hFFFF_FFFF);
    offer_reading(16'sd12345, 16'sd1571, 32'd1000000);
    offer_reading(-16'sd1, 16'sd1, 32'd1);
    offer_reading(16'sd1, -16'sd1, 32'd1);
    // repeated timestamp
    offer_reading(16'sh7FFF, -16'sh8000, 32'd0);
    offer_reading(-16'sh8000, 16'sh7FFF, 32'h8000_0000);
    offer_reading(16'sd0, 16'sh7FFF, 32'h7FFF_FFFF);
    offer_reading(16'sd100, 16'sd3142, 32'd1000000);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      spd = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 4000) - 2000);
      rate = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 8000) - 4000);
      if (pick < 75)
        delta = $urandom_range(1, 200000);
      else if (pick < 85)
        delta = $urandom;
      else if (pick < 92)
        delta = 32'd0;
      else
        delta = $urandom - stamp;
      offer_reading(spd, rate, delta);
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    while (poses_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("unicycle_odometry_integrator_top test passed");
    end else begin
      $display("unicycle_odometry_integrator_top test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/odo_pkg.sv
rtl/odo_if.sv
rtl/odo_datapath.sv
rtl/odo_ctrl.sv
rtl/unicycle_odometry_integrator_top.sv
dv/pose_checker.sv
dv/tb_unicycle_odometry_integrator_top.sv
